// ----- src/qtt_pkg.sv -----
// ----------------------------------------------------------------------------
// qtt_pkg
// Shared types and character codes for the query text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qtt_pkg;

	localparam int unsigned MaxResults = 4;

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_END_TOKEN = 2'd1,
		KIND_END_INSTR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_char;
		logic       token_start;
		logic       last;
	} result_t;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LOW_I   = 8'h69;
	localparam logic [7:0] CH_UP_I    = 8'h49;
	localparam logic [7:0] CH_LOW_N   = 8'h6E;
	localparam logic [7:0] CH_UP_N    = 8'h4E;

endpackage

`default_nettype wire

// ----- src/qtt_if.sv -----
// ----------------------------------------------------------------------------
// qtt_in_if / qtt_out_if
// Valid/ready channels for query bytes in and token results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

interface qtt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_char;
	logic       token_start;
	logic       last;

	modport source (output valid, output kind, output out_char, output token_start,
		output last, input ready);
	modport sink   (input valid, input kind, input out_char, input token_start,
		input last, output ready);
endinterface

`default_nettype wire

// ----- src/query_text_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// query_text_tokenizer_top
// Splits a byte stream of query text into token characters, token ends and
// instruction ends.
// ----------------------------------------------------------------------------
// The first result of a word is registered and appears in the cycle after the
// word is accepted. Throughput: one word per cycle while each word yields at
// most one result and tokens.ready is high; a word with more results (up to
// four) holds the four-entry shift queue until its last result leaves, since
// results leave it one per cycle while tokens.ready is high. Reset clears the
// parenthesis flag, open-word count and result queue, not the held characters.
// ----------------------------------------------------------------------------
`default_nettype none

module query_text_tokenizer_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	qtt_in_if.sink     query,
	qtt_out_if.source  tokens
);
	import qtt_pkg::*;

	logic       in_paren_q;
	logic [1:0] word_length_q;
	logic [7:0] held_first_q;
	logic [7:0] held_second_q;

	result_t    res_s1 [MaxResults];
	logic [2:0] cnt_s1;

	result_t    res_new [MaxResults];
	logic [2:0] n_new;

	logic is_sep, is_semi, is_in, take, accept;
	logic [7:0] c;

	assign c       = query.in_char;
	assign is_semi = (c == CH_SEMI);
	assign is_sep  = (c == CH_NEWLINE) || is_semi || ((c == CH_SPACE) && !in_paren_q);
	assign is_in   = ((held_first_q == CH_LOW_I) || (held_first_q == CH_UP_I)) &&
		((held_second_q == CH_LOW_N) || (held_second_q == CH_UP_N));

	assign take   = tokens.valid && tokens.ready;
	assign accept = query.valid && query.ready;

	// take a new word once the queue is empty or its final result leaves now
	assign query.ready = (cnt_s1 == 3'd0) || ((cnt_s1 == 3'd1) && tokens.ready);

	always_comb begin
		n_new = 3'd0;
		for (int i = 0; i < MaxResults; i++) begin
			res_new[i] = '{kind: KIND_CHAR, out_char: 8'h00, token_start: 1'b0,
				last: 1'b0};
		end
		if (is_sep) begin
			unique case (word_length_q)
				2'd1: begin
					res_new[0] = '{KIND_CHAR, held_first_q, 1'b1, 1'b0};
					res_new[1] = '{KIND_END_TOKEN, 8'h00, 1'b0, 1'b0};
					n_new = 3'd2;
				end
				2'd2: begin
					if (!is_in) begin
						res_new[0] = '{KIND_CHAR, held_first_q, 1'b1, 1'b0};
						res_new[1] = '{KIND_CHAR, held_second_q, 1'b0, 1'b0};
						res_new[2] = '{KIND_END_TOKEN, 8'h00, 1'b0, 1'b0};
						n_new = 3'd3;
					end
				end
				2'd3: begin
					res_new[0] = '{KIND_END_TOKEN, 8'h00, 1'b0, 1'b0};
					n_new = 3'd1;
				end
				default: begin
				end
			endcase
			if (is_semi) begin
				res_new[n_new[1:0]] = '{KIND_END_INSTR, 8'h00, 1'b0, 1'b0};
				n_new = n_new + 3'd1;
			end
		end else if (c != CH_SPACE) begin
			unique case (word_length_q)
				2'd2: begin
					res_new[0] = '{KIND_CHAR, held_first_q, 1'b1, 1'b0};
					res_new[1] = '{KIND_CHAR, held_second_q, 1'b0, 1'b0};
					res_new[2] = '{KIND_CHAR, c, 1'b0, 1'b0};
					n_new = 3'd3;
				end
				2'd3: begin
					res_new[0] = '{KIND_CHAR, c, 1'b0, 1'b0};
					n_new = 3'd1;
				end
				default: begin
				end
			endcase
		end
		for (int i = 0; i < MaxResults; i++) begin
			res_new[i].last = (3'(i + 1) == n_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_paren_q    <= 1'b0;
			word_length_q <= 2'd0;
		end else if (accept) begin
			if (is_sep) begin
				word_length_q <= 2'd0;
			end else if (c != CH_SPACE) begin
				if (c == CH_LPAREN) begin
					in_paren_q <= 1'b1;
				end else if (c == CH_RPAREN) begin
					in_paren_q <= 1'b0;
				end
				if (word_length_q != 2'd3) begin
					word_length_q <= word_length_q + 2'd1;
				end
			end
		end
	end

	// held characters carry no reset
	always_ff @(posedge clk) begin
		if (accept && !is_sep && (c != CH_SPACE)) begin
			if (word_length_q == 2'd0) begin
				held_first_q <= c;
			end
			if (word_length_q == 2'd1) begin
				held_second_q <= c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 3'd0;
		end else if (accept) begin
			cnt_s1 <= n_new;
		end else if (take) begin
			cnt_s1 <= cnt_s1 - 3'd1;
		end
	end

	// load on accept, else advance the queue by one on each take
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MaxResults; i++) begin
				res_s1[i] <= res_new[i];
			end
		end else if (take) begin
			for (int i = 0; i < MaxResults - 1; i++) begin
				res_s1[i] <= res_s1[i + 1];
			end
		end
	end

	assign tokens.valid       = (cnt_s1 != 3'd0);
	assign tokens.kind        = res_s1[0].kind;
	assign tokens.out_char    = res_s1[0].out_char;
	assign tokens.token_start = res_s1[0].token_start;
	assign tokens.last        = res_s1[0].last;

endmodule

`default_nettype wire
